@@ sv/dense_graph_shortest_paths_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the shortest path block
// Implication checks sampled on the rising clock, off while reset is low.
// ----------------------------------------------------------------------------
`ifndef DENSE_GRAPH_SHORTEST_PATHS_ASSERT_SVH
`define DENSE_GRAPH_SHORTEST_PATHS_ASSERT_SVH

// same-cycle implication
`define DGSP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("dgsp check failed");

// next-cycle implication
`define DGSP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("dgsp check failed");

`endif

@@ sv/dgsp_pkg.sv @@
// ----------------------------------------------------------------------------
// dgsp_pkg
// Shared types and constants of the dense graph shortest path block.
// ----------------------------------------------------------------------------
package dgsp_pkg;

  localparam int unsigned DIST_BITS     = 14;
  localparam int unsigned VERTEX_BITS   = 4;
  localparam int unsigned RESULT_CAP    = 16;
  localparam int unsigned IN_DATA_BITS  = 24;
  localparam int unsigned OUT_DATA_BITS = 24;
  localparam int unsigned FIELD_W_BITS  = 8;

  localparam logic [DIST_BITS-1:0] UNREACHABLE = 14'd10000;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_RUN  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SELECT,
    ST_PICK,
    ST_RELAX,
    ST_OUT_RD,
    ST_OUT_SHOW
  } state_e;

endpackage

@@ sv/dgsp_adj_mem.sv @@
// ----------------------------------------------------------------------------
// dgsp_adj_mem
// Adjacency weight memory, one weight per entry, swept to zero after reset.
// ----------------------------------------------------------------------------
module dgsp_adj_mem #(
  parameter int VERTICES    = 16,
  parameter int WEIGHT_BITS = 8,
  parameter int AW          = $clog2(VERTICES * VERTICES)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  output logic                   busy_o,
  input  logic                   we_i,
  input  logic [AW-1:0]          waddr_i,
  input  logic [WEIGHT_BITS-1:0] wdata_i,
  input  logic                   re_i,
  input  logic [AW-1:0]          raddr_i,
  output logic [WEIGHT_BITS-1:0] rdata_o
);

  localparam int DEPTH = VERTICES * VERTICES;

  logic [WEIGHT_BITS-1:0] mem [DEPTH];
  logic [AW-1:0]          clr_addr_q, clr_addr_d;
  logic                   busy_q, busy_d;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [WEIGHT_BITS-1:0] mem_wdata;

  always_comb begin
    clr_addr_d = clr_addr_q;
    busy_d     = busy_q;
    if (busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      busy_q     <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      busy_q     <= busy_d;
    end
  end

  // clearing sweep owns the write port until done
  assign mem_we    = busy_q | we_i;
  assign mem_waddr = busy_q ? clr_addr_q : waddr_i;
  assign mem_wdata = busy_q ? '0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

  assign busy_o = busy_q;

endmodule

@@ sv/dgsp_dist_ram.sv @@
// ----------------------------------------------------------------------------
// dgsp_dist_ram
// Best distance store, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module dgsp_dist_ram #(
  parameter int VERTICES = 16,
  parameter int VW       = $clog2(VERTICES)
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [VW-1:0]                  waddr_i,
  input  logic [dgsp_pkg::DIST_BITS-1:0] wdata_i,
  input  logic                           re_i,
  input  logic [VW-1:0]                  raddr_i,
  output logic [dgsp_pkg::DIST_BITS-1:0] rdata_o
);

  import dgsp_pkg::*;

  logic [DIST_BITS-1:0] mem [VERTICES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ sv/dense_graph_shortest_paths.sv @@
// ----------------------------------------------------------------------------
// dense_graph_shortest_paths
// Single-source shortest paths over a weighted adjacency matrix.
// ----------------------------------------------------------------------------
// A load beat (tuser 0) writes one weight. A run beat (tuser 1) starts a
// search: the distance store is seeded (ST_INIT), then each vertex that gets
// picked takes a min scan (ST_SELECT, ST_PICK) and an edge relaxation pass
// (ST_RELAX), one more scan finds nothing left, and min(V,16) results are
// sent, each read in ST_OUT_RD and shown in ST_OUT_SHOW. The scans walk the
// one read port of the distance memory one vertex per cycle. Input is
// taken only while no run is in progress. After reset the adjacency memory
// is swept to zero before the first beat is taken.
// ----------------------------------------------------------------------------
module dense_graph_shortest_paths #(
  parameter int VERTICES    = 16,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // row [3:0], col [7:4], weight [15:8], source [19:16], zero [23:20]
  input  logic [dgsp_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  // func [0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // vertex [3:0], distance [17:4], zero [23:18]
  output logic [dgsp_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  output logic                               m_axis_tlast
);

  import dgsp_pkg::*;

  localparam int VW   = $clog2(VERTICES);
  localparam int AW   = $clog2(VERTICES * VERTICES);
  localparam int CNT  = (VERTICES < RESULT_CAP) ? VERTICES : RESULT_CAP;
  localparam int WEXT = (WEIGHT_BITS > FIELD_W_BITS) ? WEIGHT_BITS : FIELD_W_BITS;
  localparam int SW   = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;
  localparam logic [VW-1:0] LAST_V   = VW'(VERTICES - 1);
  localparam logic [VW-1:0] LAST_OUT = VW'(CNT - 1);

  // input fields
  logic [3:0]              in_row, in_col, in_source;
  logic [FIELD_W_BITS-1:0] in_weight;
  logic [WEXT-1:0]         weight_ext;
  logic                    in_beat, load_ok;

  assign in_row     = s_axis_tdata[3:0];
  assign in_col     = s_axis_tdata[7:4];
  assign in_weight  = s_axis_tdata[15:8];
  assign in_source  = s_axis_tdata[19:16];
  assign weight_ext = WEXT'(in_weight);
  assign in_beat    = s_axis_tvalid & s_axis_tready;
  assign load_ok    = (int'(in_row) < VERTICES) && (int'(in_col) < VERTICES);

  state_e state_q, state_d;

  logic [VW-1:0]        idx_q, idx_d;
  logic [VW-1:0]        pidx_q, pidx_d;
  logic [VW-1:0]        u_q, u_d;
  logic                 pend_q, pend_d;
  logic                 iss_done_q, iss_done_d;
  logic                 found_q, found_d;
  logic [DIST_BITS-1:0] least_q, least_d;
  logic [3:0]           src_q, src_d;
  logic [VERTICES-1:0]  visited_q, visited_d;

  // memory ports
  logic                   adj_busy, adj_we, adj_re;
  logic [AW-1:0]          adj_waddr, adj_raddr;
  logic [WEIGHT_BITS-1:0] adj_wdata, adj_rdata;
  logic                   dist_we, dist_re;
  logic [VW-1:0]          dist_waddr;
  logic [DIST_BITS-1:0]   dist_wdata, dist_rdata;

  logic                 issue, scan_end, sel_hit, relax_wr, src_ok, out_last;
  logic [DIST_BITS-1:0] init_val, sat_sum;
  logic [SW-1:0]        sum;

  dgsp_adj_mem #(
    .VERTICES    (VERTICES),
    .WEIGHT_BITS (WEIGHT_BITS),
    .AW          (AW)
  ) u_adj_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .busy_o  (adj_busy),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .re_i    (adj_re),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  dgsp_dist_ram #(
    .VERTICES (VERTICES),
    .VW       (VW)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .re_i    (dist_re),
    .raddr_i (idx_q),
    .rdata_o (dist_rdata)
  );

  // compare stage, in the cycle after the read issue
  assign issue    = ((state_q == ST_SELECT) || (state_q == ST_RELAX)) && !iss_done_q;
  assign scan_end = pend_q && (pidx_q == LAST_V);
  assign sel_hit  = (state_q == ST_SELECT) && pend_q && !visited_q[pidx_q]
                    && (dist_rdata < least_q);
  assign sum      = SW'(least_q) + SW'(adj_rdata);
  assign sat_sum  = (sum > SW'(UNREACHABLE)) ? UNREACHABLE : sum[DIST_BITS-1:0];
  assign relax_wr = (state_q == ST_RELAX) && pend_q && !visited_q[pidx_q]
                    && (adj_rdata != '0) && (dist_rdata > sat_sum);
  assign src_ok   = int'(src_q) < VERTICES;
  assign init_val = (src_ok && (int'(idx_q) == int'(src_q))) ? '0 : UNREACHABLE;
  assign out_last = idx_q == LAST_OUT;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat && (func_e'(s_axis_tuser) == FUNC_RUN)) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        if (idx_q == LAST_V) begin
          state_d = ST_SELECT;
        end
      end
      ST_SELECT: begin
        if (scan_end) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        state_d = found_q ? ST_RELAX : ST_OUT_RD;
      end
      ST_RELAX: begin
        if (scan_end) begin
          state_d = ST_SELECT;
        end
      end
      ST_OUT_RD: begin
        state_d = ST_OUT_SHOW;
      end
      ST_OUT_SHOW: begin
        if (m_axis_tready) begin
          state_d = out_last ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // port and memory controls
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE) && !adj_busy;
    m_axis_tvalid = state_q == ST_OUT_SHOW;
    m_axis_tdata  = OUT_DATA_BITS'({dist_rdata, VERTEX_BITS'(idx_q)});
    m_axis_tlast  = out_last;

    adj_we    = in_beat && (func_e'(s_axis_tuser) == FUNC_LOAD) && load_ok;
    adj_waddr = AW'(int'(in_row) * VERTICES + int'(in_col));
    adj_wdata = weight_ext[WEIGHT_BITS-1:0];
    adj_re    = issue && (state_q == ST_RELAX);
    adj_raddr = AW'(int'(u_q) * VERTICES + int'(idx_q));

    dist_re    = issue || (state_q == ST_OUT_RD);
    dist_we    = (state_q == ST_INIT) || relax_wr;
    dist_waddr = (state_q == ST_INIT) ? idx_q : pidx_q;
    dist_wdata = (state_q == ST_INIT) ? init_val : sat_sum;
  end

  // datapath
  always_comb begin
    idx_d      = idx_q;
    pidx_d     = idx_q;
    pend_d     = issue;
    iss_done_d = iss_done_q;
    u_d        = u_q;
    found_d    = found_q;
    least_d    = least_q;
    src_d      = src_q;
    visited_d  = visited_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_beat && (func_e'(s_axis_tuser) == FUNC_RUN)) begin
          src_d     = in_source;
          visited_d = '0;
          idx_d     = '0;
        end
      end
      ST_INIT: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == LAST_V) begin
          idx_d      = '0;
          iss_done_d = 1'b0;
          least_d    = UNREACHABLE;
          found_d    = 1'b0;
        end
      end
      ST_SELECT, ST_RELAX: begin
        if (issue) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == LAST_V) begin
            iss_done_d = 1'b1;
          end
        end
        // strict compare keeps the lowest index on ties
        if (sel_hit) begin
          least_d = dist_rdata;
          u_d     = pidx_q;
          found_d = 1'b1;
        end
        if ((state_q == ST_RELAX) && scan_end) begin
          idx_d      = '0;
          iss_done_d = 1'b0;
          least_d    = UNREACHABLE;
          found_d    = 1'b0;
        end
      end
      ST_PICK: begin
        idx_d      = '0;
        iss_done_d = 1'b0;
        if (found_q) begin
          visited_d[u_q] = 1'b1;
        end
      end
      ST_OUT_RD: begin
      end
      ST_OUT_SHOW: begin
        if (m_axis_tready && !out_last) begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      pidx_q     <= '0;
      pend_q     <= 1'b0;
      iss_done_q <= 1'b0;
      u_q        <= '0;
      found_q    <= 1'b0;
      least_q    <= UNREACHABLE;
      src_q      <= '0;
      visited_q  <= '0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      pidx_q     <= pidx_d;
      pend_q     <= pend_d;
      iss_done_q <= iss_done_d;
      u_q        <= u_d;
      found_q    <= found_d;
      least_q    <= least_d;
      src_q      <= src_d;
      visited_q  <= visited_d;
    end
  end

endmodule

@@ sv/dgsp_checker.sv @@
// ----------------------------------------------------------------------------
// dgsp_checker
// Port-level checks of the shortest path block, bound to the top level.
// ----------------------------------------------------------------------------
`include "dense_graph_shortest_paths_assert.svh"

module dgsp_checker #(
  parameter int VERTICES = 16
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [dgsp_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input logic                               m_axis_tlast
);

  import dgsp_pkg::*;

  localparam int CNT = (VERTICES < RESULT_CAP) ? VERTICES : RESULT_CAP;

  logic [VERTEX_BITS-1:0] out_vertex;
  logic [DIST_BITS-1:0]   out_dist;
  logic                   last_idx;

  assign out_vertex = m_axis_tdata[VERTEX_BITS-1:0];
  assign out_dist   = m_axis_tdata[VERTEX_BITS+DIST_BITS-1:VERTEX_BITS];
  assign last_idx   = out_vertex == VERTEX_BITS'(CNT - 1);

  // tlast marks exactly the final vertex of a run
  `DGSP_ASSERT_IMP(a_last_pos, clk_i, rst_ni, m_axis_tvalid, m_axis_tlast == last_idx)
  // distances never pass the unreachable mark
  `DGSP_ASSERT_IMP(a_dist_cap, clk_i, rst_ni, m_axis_tvalid, out_dist <= UNREACHABLE)
  // no new beat taken while results are pending
  `DGSP_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
                   !m_axis_tvalid)
  // results of a run come in vertex order
  `DGSP_ASSERT_NXT(a_in_order, clk_i, rst_ni,
                   m_axis_tvalid && m_axis_tready && !m_axis_tlast,
                   !m_axis_tvalid || (out_vertex == $past(out_vertex) + 1'b1))
  // stalled result beat holds
  `DGSP_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind dense_graph_shortest_paths dgsp_checker #(
  .VERTICES (VERTICES)
) u_dgsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
